/* src/lzss_pkg.sv */
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared constants and types of the LZSS token decompressor.
// ----------------------------------------------------------------------------
package lzss_pkg;

  // History ring, a power of two so pointers wrap naturally
  localparam int HIST_DEPTH  = 32768;
  localparam int HIST_AW     = $clog2(HIST_DEPTH);
  localparam int FILL_W      = HIST_AW + 1;

  // Output grouping
  localparam int GROUP_BYTES = 8;
  localparam int GIDX_W      = $clog2(GROUP_BYTES);
  localparam int GCNT_W      = $clog2(GROUP_BYTES + 1);

  // Token fields
  localparam int LEN_W       = 8;
  localparam int DIST_W      = 16;
  localparam int REM_W       = LEN_W + 1;
  localparam int MATCH_BASE  = 3;
  localparam int SIZE_W      = 32;

  typedef logic [7:0] byte_t;

  // One byte in flight between read issue and write back
  typedef struct packed {
    logic               valid;
    logic               is_lit;
    byte_t              literal;
    logic               zero;    // copy source outside history
    logic               fwd;     // source is the byte written just before
    logic               last;    // final byte of the token
    logic               finish;  // count reaches expected size with this byte
    logic [HIST_AW-1:0] waddr;
  } issue_t;

  // History write port
  typedef struct packed {
    logic               en;
    logic [HIST_AW-1:0] addr;
    byte_t              data;
  } hist_wr_t;

endpackage

/* src/lzss_token_decompressor.sv */
// ----------------------------------------------------------------------------
// lzss_token_decompressor
// LZSS token decompressor with a 32 KiB history ring.
// ----------------------------------------------------------------------------
// Usage:
//   Tokens enter on the s_axis channel; tuser is the kind (0 literal,
//   1 length-distance pair). Results leave on m_axis as groups of up to
//   eight bytes; tlast marks the final group of a token and tuser flags the
//   group with which the byte count reaches the expected size.
//   expected_size is to be written through the cfg channel while the block
//   is idle; the block itself does not enforce this. Bytes are produced
//   one per cycle through the history RAM unless the byte stage is held,
//   each match read issued ahead of its write back. A new token is taken
//   only after every byte of the previous one has been issued; a group is
//   offered once its last byte has been taken into the output register.
//   A stalled receiver holds the output register; the byte pipeline halts
//   only when a finished group has no room, so up to one more group builds
//   up before tokens stop being taken.
//   Reset clears pointers, counters and the finished state; history needs
//   no clearing since bytes beyond the fill level read as zero. Once
//   finished, further tokens are taken and dropped without results.
// ----------------------------------------------------------------------------
module lzss_token_decompressor (
  input  logic        clk,
  input  logic        rst,
  // tokens
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // literal_value[7:0], length_code[15:8], distance[31:16]
  input  logic        s_axis_tuser,   // is_match
  // groups
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // out_byte0..7[63:0], byte_count[67:64], zero[71:68]
  output logic        m_axis_tlast,   // last_of_token
  output logic        m_axis_tuser,   // finished
  // expected size register
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);
  import lzss_pkg::*;

  logic               rd_en;
  logic [HIST_AW-1:0] rd_addr;
  byte_t              rd_data;
  issue_t             stage;
  logic               take;
  hist_wr_t           wr;
  byte_t              out_bytes [GROUP_BYTES];
  logic [GCNT_W-1:0]  out_count;

  assign cfg_ready = 1'b1;

  lzss_copy_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .tok_valid    (s_axis_tvalid),
    .tok_ready    (s_axis_tready),
    .tok_is_match (s_axis_tuser),
    .tok_literal  (s_axis_tdata[7:0]),
    .tok_length   (s_axis_tdata[15:8]),
    .tok_distance (s_axis_tdata[31:16]),
    .cfg_we       (cfg_valid),
    .cfg_value    (cfg_data),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .stage        (stage),
    .take         (take)
  );

  lzss_hist_ram #(
    .ADDR_W (HIST_AW),
    .DATA_W (8)
  ) u_hist (
    .clk   (clk),
    .we    (wr.en),
    .waddr (wr.addr),
    .wdata (wr.data),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lzss_group_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .rd_data    (rd_data),
    .take       (take),
    .wr         (wr),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_bytes  (out_bytes),
    .out_count  (out_count),
    .out_last   (m_axis_tlast),
    .out_finish (m_axis_tuser)
  );

  // pack the group onto tdata
  always_comb begin
    m_axis_tdata = '0;
    for (int i = 0; i < GROUP_BYTES; i++) begin
      m_axis_tdata[8*i +: 8] = out_bytes[i];
    end
    m_axis_tdata[67:64] = out_count;
  end

endmodule

/* src/lzss_hist_ram.sv */
// ----------------------------------------------------------------------------
// lzss_hist_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lzss_hist_ram #(
  parameter int ADDR_W = 15,
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/lzss_copy_engine.sv */
// ----------------------------------------------------------------------------
// lzss_copy_engine
// Token sequencer: issues one history read per copied byte of a match and keeps the
// write pointer, fill level, byte count and end-of-stream state.
// ----------------------------------------------------------------------------
module lzss_copy_engine (
  input  logic                        clk,
  input  logic                        rst,
  // token input
  input  logic                        tok_valid,
  output logic                        tok_ready,
  input  logic                        tok_is_match,
  input  lzss_pkg::byte_t             tok_literal,
  input  logic [lzss_pkg::LEN_W-1:0]  tok_length,
  input  logic [lzss_pkg::DIST_W-1:0] tok_distance,
  // expected size register
  input  logic                        cfg_we,
  input  logic [lzss_pkg::SIZE_W-1:0] cfg_value,
  // history read
  output logic                        rd_en,
  output logic [lzss_pkg::HIST_AW-1:0] rd_addr,
  // byte stage toward the packer
  output lzss_pkg::issue_t            stage,
  input  logic                        take
);
  import lzss_pkg::*;

  logic               busy;
  logic [REM_W-1:0]   rem;
  logic               is_match;
  byte_t              literal;
  logic [DIST_W-1:0]  distance;
  logic [HIST_AW-1:0] wp;
  logic [FILL_W-1:0]  fill;
  logic [SIZE_W-1:0]  produced;
  logic               done;
  logic [SIZE_W-1:0]  expected;

  logic               accept;
  logic               issue;
  logic               last_byte;
  logic               src_zero;
  logic [SIZE_W-1:0]  produced_next;

  assign tok_ready = !busy;
  assign accept    = tok_valid && !busy;

  // one byte leaves per cycle unless the stage is held
  assign issue         = busy && (!stage.valid || take);
  assign last_byte     = (rem == REM_W'(1));
  assign produced_next = produced + SIZE_W'(1);
  assign src_zero      = (distance == '0) || (distance > DIST_W'(fill));

  // copy source trails the write pointer by the distance
  assign rd_en   = issue && is_match;
  assign rd_addr = wp - distance[HIST_AW-1:0];

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      expected <= '0;
    end else if (cfg_we) begin
      expected <= cfg_value;
    end
  end

  // token sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      rem  <= '0;
      done <= 1'b0;
    end else if (accept) begin
      // tokens after the end are dropped
      busy <= !done;
      rem  <= tok_is_match ? ({1'b0, tok_length} + REM_W'(MATCH_BASE)) : REM_W'(1);
    end else if (issue) begin
      rem <= rem - REM_W'(1);
      if (last_byte) begin
        busy <= 1'b0;
        if (produced_next == expected) begin
          done <= 1'b1;
        end
      end
    end
  end

  // token payload
  always_ff @(posedge clk) begin
    if (accept) begin
      is_match <= tok_is_match;
      literal  <= tok_literal;
      distance <= tok_distance;
    end
  end

  // stream position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      wp       <= '0;
      fill     <= '0;
      produced <= '0;
    end else if (issue) begin
      wp       <= wp + HIST_AW'(1);
      produced <= produced_next;
      if (fill != FILL_W'(HIST_DEPTH)) begin
        fill <= fill + FILL_W'(1);
      end
    end
  end

  // byte stage
  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (issue) begin
      stage.valid <= 1'b1;
    end else if (take) begin
      stage.valid <= 1'b0;
    end
    if (issue) begin
      stage.is_lit  <= !is_match;
      stage.literal <= literal;
      stage.zero    <= src_zero;
      stage.fwd     <= (distance == DIST_W'(1));
      stage.last    <= last_byte;
      stage.finish  <= last_byte && (produced_next == expected);
      stage.waddr   <= wp;
    end
  end

endmodule

/* src/lzss_group_packer.sv */
// ----------------------------------------------------------------------------
// lzss_group_packer
// Resolves each byte, writes it back to history and packs bytes into
// output groups held in the output register.
// ----------------------------------------------------------------------------
module lzss_group_packer (
  input  logic                          clk,
  input  logic                          rst,
  input  lzss_pkg::issue_t              stage,
  input  lzss_pkg::byte_t               rd_data,
  output logic                          take,
  output lzss_pkg::hist_wr_t            wr,
  // output register
  output logic                          out_valid,
  input  logic                          out_ready,
  output lzss_pkg::byte_t               out_bytes [lzss_pkg::GROUP_BYTES],
  output logic [lzss_pkg::GCNT_W-1:0]   out_count,
  output logic                          out_last,
  output logic                          out_finish
);
  import lzss_pkg::*;

  byte_t             gbuf [GROUP_BYTES];
  logic [GCNT_W-1:0] gcnt;
  byte_t             prev_byte;

  byte_t             cur;
  logic              complete;
  logic              stall;

  // byte value: literal, out of range, run of one, or history
  always_comb begin
    if (stage.is_lit) begin
      cur = stage.literal;
    end else if (stage.zero) begin
      cur = '0;
    end else if (stage.fwd) begin
      cur = prev_byte;
    end else begin
      cur = rd_data;
    end
  end

  assign complete = (gcnt == GCNT_W'(GROUP_BYTES - 1)) || stage.last;
  assign stall    = stage.valid && complete && out_valid && !out_ready;
  assign take     = stage.valid && !stall;

  assign wr.en   = take;
  assign wr.addr = stage.waddr;
  assign wr.data = cur;

  // last written byte, source of distance-one copies
  always_ff @(posedge clk) begin
    if (take) begin
      prev_byte <= cur;
    end
  end

  // group buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      gcnt <= '0;
    end else if (take) begin
      if (complete) begin
        gcnt <= '0;
      end else begin
        gcnt <= gcnt + GCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && !complete) begin
      gbuf[gcnt[GIDX_W-1:0]] <= cur;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && complete) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && complete) begin
      for (int i = 0; i < GROUP_BYTES; i++) begin
        if (GCNT_W'(i) < gcnt) begin
          out_bytes[i] <= gbuf[i];
        end else if (GCNT_W'(i) == gcnt) begin
          out_bytes[i] <= cur;
        end else begin
          out_bytes[i] <= '0;
        end
      end
      out_count  <= gcnt + GCNT_W'(1);
      out_last   <= stage.last;
      out_finish <= stage.finish;
    end
  end

endmodule

/* tb/tb_lzss_token_decompressor.sv */
// ----------------------------------------------------------------------------
// tb_lzss_token_decompressor
// Self-checking testbench for the LZSS token decompressor.
// ----------------------------------------------------------------------------
// Tokens go in through a queue-fed driver and are decoded at transfer time by
// a model of the history ring kept in the testbench. The resulting byte groups
// are queued and compared field by field with every group the block emits.
// A directed set of corner tokens is followed by random token streams under
// three idle patterns. The run ends with a stream that lands exactly on the
// expected size, followed by tokens that must be dropped.
// ----------------------------------------------------------------------------
module tb_lzss_token_decompressor;
  timeunit 1ns;
  timeprecision 1ps;

  import lzss_pkg::*;

  typedef struct packed {
    logic              is_match;
    logic [7:0]        lit;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
  } token_t;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        fin;
  } out_group_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        m_axis_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  lzss_token_decompressor dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // literal_value[7:0], length_code[15:8], distance[31:16]
    .s_axis_tuser  (s_axis_tuser),   // is_match
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // out_byte0..7[63:0], byte_count[67:64], zero[71:68]
    .m_axis_tlast  (m_axis_tlast),   // last_of_token
    .m_axis_tuser  (m_axis_tuser),   // finished
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always #5 clk = ~clk;

  // Stimulus and expectation stores
  token_t      token_backlog[$];
  out_group_t  pending_groups[$];
  token_t      token_on_bus;
  out_group_t  group_want;
  int unsigned tokens_queued = 0;
  int unsigned tokens_taken  = 0;
  int unsigned queued_bytes  = 0;   // bytes the queued tokens will produce
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned errors        = 0;

  // Decoder state mirror
  logic [7:0]  hist_mem[HIST_DEPTH];
  int unsigned wr_pos     = 0;
  int unsigned hist_fill  = 0;
  logic [31:0] out_total  = '0;
  logic [31:0] size_target = '0;
  logic        decode_done = 1'b0;

  // Decode one token into its output groups
  function automatic void decode_token(input token_t t);
    int unsigned total;
    int unsigned fill;
    logic [7:0]  b;
    out_group_t  g;
    if (decode_done) return;
    total = t.is_match ? t.len + MATCH_BASE : 1;
    fill  = 0;
    g     = '0;
    for (int unsigned k = 0; k < total; k++) begin
      if (!t.is_match) b = t.lit;
      else if (t.distance == 0 || t.distance > hist_fill) b = 8'h00;
      else b = hist_mem[(wr_pos - t.distance) & (HIST_DEPTH - 1)];
      hist_mem[wr_pos] = b;
      wr_pos    = (wr_pos + 1) % HIST_DEPTH;
      out_total = out_total + 32'd1;
      if (hist_fill < HIST_DEPTH) hist_fill++;
      g.data[fill*8 +: 8] = b;
      fill++;
      g.count = 4'(fill);
      // full group that is not the token's last one leaves now
      if (fill == GROUP_BYTES && k != total - 1) begin
        pending_groups.push_back(g);
        g    = '0;
        fill = 0;
      end
    end
    g.last = 1'b1;
    if (out_total == size_target) begin
      g.fin       = 1'b1;
      decode_done = 1'b1;
    end
    pending_groups.push_back(g);
  endfunction

  function automatic void check_field(input string name, input int unsigned want_v,
                                      input int unsigned got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0h, got %0h", name, want_v, got_v);
      errors++;
    end
  endfunction

  // Token driver: predicts on each transfer, then offers the next token
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        decode_token(token_on_bus);
        tokens_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (token_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          token_on_bus = token_backlog.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {token_on_bus.distance, token_on_bus.len, token_on_bus.lit};
          s_axis_tuser  <= token_on_bus.is_match;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Group monitor and receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_groups.size() == 0) begin
          $error("group transfer with no group expected");
          errors++;
        end else begin
          group_want = pending_groups.pop_front();
          for (int i = 0; i < GROUP_BYTES; i++)
            check_field($sformatf("out_byte%0d", i), group_want.data[i*8 +: 8],
                        m_axis_tdata[i*8 +: 8]);
          check_field("byte_count", group_want.count, m_axis_tdata[67:64]);
          check_field("tdata pad", 0, m_axis_tdata[71:68]);
          check_field("last_of_token", group_want.last, m_axis_tlast);
          check_field("finished", group_want.fin, m_axis_tuser);
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic queue_token(input token_t t);
    token_backlog.push_back(t);
    tokens_queued++;
    queued_bytes += t.is_match ? t.len + MATCH_BASE : 1;
  endtask

  // Random token; match distances mostly reach into produced history
  function automatic token_t rand_token();
    token_t      t;
    int unsigned reach;
    int unsigned sel;
    t.lit      = $urandom;
    t.len      = $urandom;
    t.distance = $urandom;
    t.is_match = ($urandom_range(99) >= 35);
    if (t.is_match) begin
      if ($urandom_range(9) < 3) t.len = $urandom_range(255);
      else t.len = $urandom_range(12);
      reach = (queued_bytes < HIST_DEPTH) ? queued_bytes : HIST_DEPTH;
      sel   = $urandom_range(19);
      if (sel == 0) t.distance = 0;
      else if (sel == 1) t.distance = $urandom;
      else if (sel == 2 || reach == 0) t.distance = reach + $urandom_range(40, 1);
      else if (sel < 8) t.distance = $urandom_range((reach < 16) ? reach : 16, 1);
      else t.distance = $urandom_range(reach, 1);
    end
    return t;
  endfunction

  task automatic write_size(input logic [31:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid   <= 1'b0;
    size_target = v;
  endtask

  // Wait until every token is taken and every group has arrived
  task automatic drain();
    while (tokens_taken != tokens_queued || pending_groups.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Run limit
  initial begin
    #10ms;
    $display("simulation failed");
    $finish;
  end

  // Test sequence
  initial begin
    int unsigned remaining;
    token_t      t;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed corners, size never reached
    write_size(32'hFFFF_FFFF);
    send_idle_pct = 7;
    recv_idle_pct = 64;
    queue_token('{1'b1, 8'hFF, 8'd0,   16'd1});      // copy from empty history
    queue_token('{1'b0, 8'h00, 8'hFF,  16'hFFFF});   // literal, match fields set
    queue_token('{1'b0, 8'hFF, 8'h00,  16'h0000});
    queue_token('{1'b0, 8'h5A, 8'h00,  16'h0000});
    queue_token('{1'b1, 8'h00, 8'd0,   16'd6});      // distance equals fill
    queue_token('{1'b1, 8'h00, 8'd1,   16'd10});     // one past fill, then in range
    queue_token('{1'b1, 8'h00, 8'd5,   16'd1});      // exactly one full group
    queue_token('{1'b1, 8'h00, 8'd6,   16'd2});      // one byte into a second group
    queue_token('{1'b1, 8'h00, 8'd13,  16'd3});      // two full groups
    queue_token('{1'b1, 8'h00, 8'd2,   16'd0});      // zero distance
    queue_token('{1'b1, 8'h00, 8'd255, 16'd2});      // longest match, overlapping
    queue_token('{1'b1, 8'hFF, 8'd255, 16'hFFFF});   // beyond history
    queue_token('{1'b1, 8'h00, 8'd10,  16'h8000});   // beyond fill
    queue_token('{1'b0, 8'h80, 8'h00,  16'h0000});
    queue_token('{1'b1, 8'h00, 8'd3,   16'h0100});
    queue_token('{1'b0, 8'h01, 8'hFF,  16'hFFFF});
    queue_token('{1'b1, 8'h00, 8'd0,   16'd1});
    drain();

    // Long matches wrap the history ring, then random tokens
    write_size(32'h0000_0000);
    for (int i = 0; i < 130; i++) begin
      t          = rand_token();
      t.is_match = 1'b1;
      t.len      = 8'd255;
      t.distance = ($urandom_range(3) == 0) ? $urandom_range(8, 1)
                                            : $urandom_range(queued_bytes < HIST_DEPTH ?
                                                             queued_bytes : HIST_DEPTH, 1);
      queue_token(t);
    end
    for (int i = 0; i < 60; i++) queue_token(rand_token());
    drain();

    // Receiver mostly ready, sender gappy
    write_size({1'b1, 31'($urandom)});
    send_idle_pct = 64;
    recv_idle_pct = 7;
    for (int i = 0; i < 140; i++) queue_token(rand_token());
    drain();

    // Overshooting match must not finish
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(queued_bytes + 5);
    queue_token('{1'b1, 8'h00, 8'd7, 16'd4});
    for (int i = 0; i < 120; i++) queue_token(rand_token());
    drain();

    // Stream that lands exactly on the size, then dropped tokens
    write_size(queued_bytes + 300 + $urandom_range(900));
    remaining = size_target - queued_bytes;
    while (remaining != 0) begin
      t = rand_token();
      if (t.is_match && remaining < MATCH_BASE) t.is_match = 1'b0;
      if (t.is_match && t.len + MATCH_BASE > remaining) t.len = 8'(remaining - MATCH_BASE);
      remaining -= t.is_match ? t.len + MATCH_BASE : 1;
      queue_token(t);
    end
    for (int i = 0; i < 6; i++) queue_token(rand_token());
    drain();

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* lzss_token_decompressor.f */
src/lzss_pkg.sv
src/lzss_hist_ram.sv
src/lzss_copy_engine.sv
src/lzss_group_packer.sv
src/lzss_token_decompressor.sv
tb/tb_lzss_token_decompressor.sv
